// File: rtl/core/vau_pkg.sv
package vau_pkg;

    typedef logic [2:0]         op_t;
    typedef logic signed [31:0] fx_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [65:0] wide_t;

    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_MUL   = 3'd2;
    localparam op_t OP_SCALE = 3'd3;
    localparam op_t OP_CROSS = 3'd4;
    localparam op_t OP_DOT   = 3'd5;
    localparam op_t OP_NORM  = 3'd6;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;

    localparam int NUM_MULS       = 6;
    localparam int ROOT_BITS      = 32;
    localparam int SQ_STEPS       = 4;
    localparam int SQ_STAGES      = ROOT_BITS / SQ_STEPS;

    typedef struct packed {
        logic  flag;
        fx_t   val;
    } sat_t;

    // One item on its way through the square-root stages
    typedef struct packed {
        logic        norm;
        logic        sat;
        fx_t         rx;
        fx_t         ry;
        fx_t         rz;
        logic [63:0] sq;
        logic [35:0] rem;
        logic [31:0] root;
    } tail_t;

    function automatic wide_t ext(input prod_t v);
        return {{2{v[63]}}, v};
    endfunction

    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        if (v[65:31] == '0 || v[65:31] == '1)
        begin
            r.flag = 1'b0;
            r.val  = v[31:0];
        end
        else
        begin
            r.flag = 1'b1;
            r.val  = v[65] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

    // Retire two radicand bits per step, one root bit per step
    function automatic tail_t sqrt_stage(input tail_t t);
        tail_t       r;
        logic [35:0] rem2;
        logic [35:0] trial;
        r = t;
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            rem2  = {r.rem[33:0], r.sq[63:62]};
            trial = {2'b00, r.root, 2'b01};
            if (rem2 >= trial)
            begin
                r.rem  = rem2 - trial;
                r.root = {r.root[30:0], 1'b1};
            end
            else
            begin
                r.rem  = rem2;
                r.root = {r.root[30:0], 1'b0};
            end
            r.sq = {r.sq[61:0], 2'b00};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/vau_req_if.sv
interface vau_req_if;
    logic          valid;
    logic          ready;
    vau_pkg::op_t  operation;
    vau_pkg::fx_t  a_x;
    vau_pkg::fx_t  a_y;
    vau_pkg::fx_t  a_z;
    vau_pkg::fx_t  b_x;
    vau_pkg::fx_t  b_y;
    vau_pkg::fx_t  b_z;
    vau_pkg::fx_t  scale_factor;

    modport source (
        output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
        input  ready
    );

    modport sink (
        input  valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
        output ready
    );
endinterface

// File: rtl/core/vau_rsp_if.sv
interface vau_rsp_if;
    logic          valid;
    logic          ready;
    vau_pkg::fx_t  r_x;
    vau_pkg::fx_t  r_y;
    vau_pkg::fx_t  r_z;
    logic          saturated;

    modport source (
        output valid, r_x, r_y, r_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, r_x, r_y, r_z, saturated,
        output ready
    );
endinterface

// File: rtl/core/vector3_arithmetic_unit_core.sv
// Items go through the input, product and combine registers, the 8-stage square-root
// chain (4 root bits per stage) and the output register; every item passes all of them,
// so results keep their order. One item per cycle while no stall holds the pipeline.
// Stalls pass back combinationally; a bubble anywhere lets a new item enter.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
module vector3_arithmetic_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    vau_req_if.sink     req,
    vau_rsp_if.source   rsp
);

    // Input stage
    logic          v_in_reg;
    vau_pkg::op_t  op_in_reg;
    vau_pkg::fx_t  ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg, s_reg;

    // Product stage
    logic          v_prod_reg;
    vau_pkg::op_t  op_prod_reg;
    vau_pkg::prod_t prod_reg [vau_pkg::NUM_MULS];
    vau_pkg::prod_t prod_next [vau_pkg::NUM_MULS];
    logic signed [32:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [32:0] sum_x_next, sum_y_next, sum_z_next;
    vau_pkg::fx_t  ma [vau_pkg::NUM_MULS];
    vau_pkg::fx_t  mb [vau_pkg::NUM_MULS];

    // Combine and square-root stages
    logic           v_tail_reg [vau_pkg::SQ_STAGES + 1];
    vau_pkg::tail_t tail_reg   [vau_pkg::SQ_STAGES + 1];
    vau_pkg::tail_t tail_next  [vau_pkg::SQ_STAGES + 1];

    // Output stage
    logic          v_out_reg;
    vau_pkg::fx_t  rx_reg, ry_reg, rz_reg;
    vau_pkg::fx_t  rx_next;
    logic          sat_reg, sat_next;

    logic          en_in, en_prod, en_out;
    logic          en_tail [vau_pkg::SQ_STAGES + 1];

    vau_pkg::wide_t w_x, w_y, w_z, sh_x, sh_y, sh_z, nsum;
    vau_pkg::sat_t  c_x, c_y, c_z;

    // A stage moves when it is empty or its successor moves
    always_comb
    begin
        en_out = !v_out_reg || rsp.ready;
        en_tail[vau_pkg::SQ_STAGES] = !v_tail_reg[vau_pkg::SQ_STAGES] || en_out;
        for (int i = vau_pkg::SQ_STAGES - 1; i >= 0; i--)
        begin
            en_tail[i] = !v_tail_reg[i] || en_tail[i + 1];
        end
        en_prod = !v_prod_reg || en_tail[0];
        en_in   = !v_in_reg || en_prod;
    end

    assign req.ready = en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_out_reg  <= 1'b0;
            for (int i = 0; i <= vau_pkg::SQ_STAGES; i++)
            begin
                v_tail_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en_in)
            begin
                v_in_reg <= req.valid;
            end
            if (en_prod)
            begin
                v_prod_reg <= v_in_reg;
            end
            if (en_tail[0])
            begin
                v_tail_reg[0] <= v_prod_reg;
            end
            for (int i = 1; i <= vau_pkg::SQ_STAGES; i++)
            begin
                if (en_tail[i])
                begin
                    v_tail_reg[i] <= v_tail_reg[i - 1];
                end
            end
            if (en_out)
            begin
                v_out_reg <= v_tail_reg[vau_pkg::SQ_STAGES];
            end
        end
    end

    // Operand selection for the six shared multipliers
    always_comb
    begin
        ma[0] = ax_reg;  mb[0] = bx_reg;
        ma[1] = ay_reg;  mb[1] = by_reg;
        ma[2] = az_reg;  mb[2] = bz_reg;
        ma[3] = az_reg;  mb[3] = by_reg;
        ma[4] = ax_reg;  mb[4] = bz_reg;
        ma[5] = ay_reg;  mb[5] = bx_reg;
        unique case (op_in_reg)
            vau_pkg::OP_SCALE:
            begin
                mb[0] = s_reg;
                mb[1] = s_reg;
                mb[2] = s_reg;
            end
            vau_pkg::OP_CROSS:
            begin
                ma[0] = ay_reg;  mb[0] = bz_reg;
                ma[1] = az_reg;  mb[1] = bx_reg;
                ma[2] = ax_reg;  mb[2] = by_reg;
            end
            vau_pkg::OP_NORM:
            begin
                mb[0] = ax_reg;
                mb[1] = ay_reg;
                mb[2] = az_reg;
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < vau_pkg::NUM_MULS; i++)
        begin
            prod_next[i] = ma[i] * mb[i];
        end

        if (op_in_reg == vau_pkg::OP_SUB)
        begin
            sum_x_next = 33'(ax_reg) - 33'(bx_reg);
            sum_y_next = 33'(ay_reg) - 33'(by_reg);
            sum_z_next = 33'(az_reg) - 33'(bz_reg);
        end
        else
        begin
            sum_x_next = 33'(ax_reg) + 33'(bx_reg);
            sum_y_next = 33'(ay_reg) + 33'(by_reg);
            sum_z_next = 33'(az_reg) + 33'(bz_reg);
        end
    end

    // Combine products, drop 16 fraction bits (sums of add and subtract are taken as they are), saturate
    always_comb
    begin
        w_x  = vau_pkg::ext(prod_reg[0]) - vau_pkg::ext(prod_reg[3]);
        w_y  = vau_pkg::ext(prod_reg[1]) - vau_pkg::ext(prod_reg[4]);
        w_z  = vau_pkg::ext(prod_reg[2]) - vau_pkg::ext(prod_reg[5]);
        nsum = vau_pkg::ext(prod_reg[0]) + vau_pkg::ext(prod_reg[1])
             + vau_pkg::ext(prod_reg[2]);
        sh_x = '0;
        sh_y = '0;
        sh_z = '0;
        tail_next[0].norm = 1'b0;
        tail_next[0].sq   = nsum[63:0];
        tail_next[0].rem  = '0;
        tail_next[0].root = '0;
        unique case (op_prod_reg) inside
            vau_pkg::OP_ADD, vau_pkg::OP_SUB:
            begin
                sh_x = {{33{sum_x_reg[32]}}, sum_x_reg};
                sh_y = {{33{sum_y_reg[32]}}, sum_y_reg};
                sh_z = {{33{sum_z_reg[32]}}, sum_z_reg};
            end
            vau_pkg::OP_MUL, vau_pkg::OP_SCALE:
            begin
                sh_x = vau_pkg::ext(prod_reg[0]) >>> 16;
                sh_y = vau_pkg::ext(prod_reg[1]) >>> 16;
                sh_z = vau_pkg::ext(prod_reg[2]) >>> 16;
            end
            vau_pkg::OP_CROSS:
            begin
                sh_x = w_x >>> 16;
                sh_y = w_y >>> 16;
                sh_z = w_z >>> 16;
            end
            vau_pkg::OP_DOT:
            begin
                sh_x = nsum >>> 16;
            end
            vau_pkg::OP_NORM:
            begin
                tail_next[0].norm = 1'b1;
            end
            default:
            begin
            end
        endcase
        c_x = vau_pkg::sat32(sh_x);
        c_y = vau_pkg::sat32(sh_y);
        c_z = vau_pkg::sat32(sh_z);
        tail_next[0].rx  = c_x.val;
        tail_next[0].ry  = c_y.val;
        tail_next[0].rz  = c_z.val;
        tail_next[0].sat = c_x.flag | c_y.flag | c_z.flag;

        for (int i = 1; i <= vau_pkg::SQ_STAGES; i++)
        begin
            tail_next[i] = vau_pkg::sqrt_stage(tail_reg[i - 1]);
        end
    end

    // Final selection of the norm result
    always_comb
    begin
        rx_next  = tail_reg[vau_pkg::SQ_STAGES].rx;
        sat_next = tail_reg[vau_pkg::SQ_STAGES].sat;
        if (tail_reg[vau_pkg::SQ_STAGES].norm)
        begin
            if (tail_reg[vau_pkg::SQ_STAGES].root[31])
            begin
                rx_next  = vau_pkg::FX_MAX;
                sat_next = 1'b1;
            end
            else
            begin
                rx_next  = tail_reg[vau_pkg::SQ_STAGES].root;
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            op_in_reg <= req.operation;
            ax_reg    <= req.a_x;
            ay_reg    <= req.a_y;
            az_reg    <= req.a_z;
            bx_reg    <= req.b_x;
            by_reg    <= req.b_y;
            bz_reg    <= req.b_z;
            s_reg     <= req.scale_factor;
        end
        if (en_prod)
        begin
            op_prod_reg <= op_in_reg;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_z_reg   <= sum_z_next;
            for (int i = 0; i < vau_pkg::NUM_MULS; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        for (int i = 0; i <= vau_pkg::SQ_STAGES; i++)
        begin
            if (en_tail[i])
            begin
                tail_reg[i] <= tail_next[i];
            end
        end
        if (en_out)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= tail_reg[vau_pkg::SQ_STAGES].ry;
            rz_reg  <= tail_reg[vau_pkg::SQ_STAGES].rz;
            sat_reg <= sat_next;
        end
    end

    assign rsp.valid     = v_out_reg;
    assign rsp.r_x       = rx_reg;
    assign rsp.r_y       = ry_reg;
    assign rsp.r_z       = rz_reg;
    assign rsp.saturated = sat_reg;

endmodule
